>>> src/dtfe_pkg.sv
// Package for the display text frame encoder: item types, op codes, frame bytes.
// Used by the controller, the datapath, the top level and the testbench.
package dtfe_pkg;

    // Op codes of a request
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_FREQ  = 2'd1;
    localparam logic [1:0] OP_DEC2  = 2'd2;
    localparam logic [1:0] OP_DEC1  = 2'd3;

    localparam logic [7:0]  ASCII_ZERO = 8'd48;
    localparam logic [7:0]  ASCII_DOT  = 8'h2E;
    localparam logic [31:0] FREQ_LIMIT = 32'd10000000;
    localparam logic [31:0] DEC2_MAX   = 32'd999;
    localparam logic [31:0] DEC1_MAX   = 32'd99;

    // Binary width converted to decimal, digit count, conversion cycles
    localparam int BIN_W      = 24;
    localparam int DIGITS     = 7;
    localparam int BITS_PER_CYC = 3;
    localparam int CONV_CYCLES  = BIN_W / BITS_PER_CYC;

    // Byte positions inside one request's stream
    localparam logic [4:0] POS_ID1    = 5'd6;
    localparam logic [4:0] POS_TAIL1  = 5'd7;
    localparam logic [4:0] POS_HEAD2  = 5'd11;
    localparam logic [4:0] POS_ID2    = 5'd17;
    localparam logic [4:0] POS_BODY   = 5'd18;
    localparam logic [4:0] LAST_CLEAR = 5'd10;
    localparam logic [4:0] TAIL_LEN_M1 = 5'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  control_id;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic conv_busy;
        logic last_byte;
    } t_status;

    function automatic logic [7:0] head_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'hEE;
            3'd1:    b = 8'hB1;
            3'd2:    b = 8'h10;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tail_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd1:    b = 8'hFC;
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

endpackage

>>> src/dtfe_chan_if.sv
// Valid/ready channel carrying one item of payload type T.
// Payload types come from dtfe_pkg.
interface dtfe_chan_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/dtfe_ctrl.sv
// Controller of the display text frame encoder: request handshake, output valid,
// and command sequencing of the datapath. Depends on dtfe_pkg.
module dtfe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dtfe_pkg::t_cmd    o_cmd,
    input  dtfe_pkg::t_status i_st
);
    import dtfe_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Issue commands
    always_comb begin
        o_cmd.load = i_in_valid && (r_state == S_IDLE);
        o_cmd.step = i_st.conv_busy;
        o_cmd.emit = (r_state == S_RUN) && out_free;
    end

    // Next state and output valid
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) n_state = S_RUN;
            end
            S_RUN: begin
                if (o_cmd.emit && i_st.last_byte) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

>>> src/dtfe_dp.sv
// Datapath of the display text frame encoder: request registers, shift-add-3
// binary to decimal converter, byte sequencer and output register. Uses dtfe_pkg.
module dtfe_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtfe_pkg::t_req    i_req,
    input  dtfe_pkg::t_cmd    i_cmd,
    output dtfe_pkg::t_status o_st,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last
);
    import dtfe_pkg::*;

    localparam int SR_W  = 4 * DIGITS + BIN_W;
    localparam int CNT_W = $clog2(CONV_CYCLES + 1);

    logic [1:0]       r_op;
    logic [7:0]       r_id;
    logic             r_text;
    logic [SR_W-1:0]  r_sr;
    logic [CNT_W-1:0] r_cnt;
    logic [4:0]       r_idx;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic [BIN_W-1:0] load_val;
    logic             load_text;
    logic [4:0]       body_len;
    logic [4:0]       last_idx;
    logic [4:0]       pos;
    logic [4:0]       tpos;
    logic [2:0]       dsel;
    logic [3:0]       digit;
    logic [7:0]       body_char;
    logic [7:0]       cur_byte;

    // Three shift-add-3 steps on the digit and binary shift register
    function automatic logic [SR_W-1:0] dd_step(input logic [SR_W-1:0] sr);
        logic [SR_W-1:0] s;
        s = sr;
        for (int b = 0; b < BITS_PER_CYC; b++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (s[BIN_W + 4*d +: 4] >= 4'd5) begin
                    s[BIN_W + 4*d +: 4] = s[BIN_W + 4*d +: 4] + 4'd3;
                end
            end
            s = {s[SR_W-2:0], 1'b0};
        end
        return s;
    endfunction

    // Saturate the value for the decimal ops; flag whether a text frame follows
    always_comb begin
        load_val  = i_req.value[BIN_W-1:0];
        load_text = 1'b1;
        case (i_req.op)
            OP_CLEAR: load_text = 1'b0;
            OP_FREQ:  load_text = (i_req.value < FREQ_LIMIT);
            OP_DEC2: begin
                if (i_req.value > DEC2_MAX) load_val = DEC2_MAX[BIN_W-1:0];
            end
            default: begin
                if (i_req.value > DEC1_MAX) load_val = DEC1_MAX[BIN_W-1:0];
            end
        endcase
    end

    // Body length and index of the final byte
    always_comb begin
        case (r_op)
            OP_FREQ: begin
                if (r_sr[BIN_W + 24 +: 4] != 4'd0)      body_len = 5'd7;
                else if (r_sr[BIN_W + 20 +: 4] != 4'd0) body_len = 5'd6;
                else if (r_sr[BIN_W + 16 +: 4] != 4'd0) body_len = 5'd5;
                else if (r_sr[BIN_W + 12 +: 4] != 4'd0) body_len = 5'd4;
                else                                     body_len = 5'd3;
            end
            OP_DEC2: body_len = 5'd4;
            default: body_len = 5'd3;
        endcase
        last_idx = r_text ? (POS_BODY + body_len + TAIL_LEN_M1) : LAST_CLEAR;
    end

    // Pick the body character
    always_comb begin
        pos  = r_idx - POS_BODY;
        tpos = pos - body_len;
        dsel = 3'd0;
        body_char = ASCII_DOT;
        case (r_op)
            OP_FREQ: dsel = body_len[2:0] - 3'd1 - pos[2:0];
            OP_DEC2: begin
                case (pos[1:0])
                    2'd0:    dsel = 3'd2;
                    2'd2:    dsel = 3'd1;
                    default: dsel = 3'd0;
                endcase
            end
            default: dsel = (pos[1:0] == 2'd0) ? 3'd1 : 3'd0;
        endcase
        case (dsel)
            3'd0:    digit = r_sr[BIN_W +  0 +: 4];
            3'd1:    digit = r_sr[BIN_W +  4 +: 4];
            3'd2:    digit = r_sr[BIN_W +  8 +: 4];
            3'd3:    digit = r_sr[BIN_W + 12 +: 4];
            3'd4:    digit = r_sr[BIN_W + 16 +: 4];
            3'd5:    digit = r_sr[BIN_W + 20 +: 4];
            default: digit = r_sr[BIN_W + 24 +: 4];
        endcase
        if (!(r_op != OP_FREQ && pos[1:0] == 2'd1)) begin
            body_char = ASCII_ZERO + {4'd0, digit};
        end
    end

    // Sequence the frame bytes
    always_comb begin
        if (r_idx < POS_ID1) begin
            cur_byte = head_byte(r_idx[2:0]);
        end else if (r_idx == POS_ID1 || r_idx == POS_ID2) begin
            cur_byte = r_id;
        end else if (r_idx < POS_HEAD2) begin
            cur_byte = tail_byte(2'(r_idx - POS_TAIL1));
        end else if (r_idx < POS_ID2) begin
            cur_byte = head_byte(3'(r_idx - POS_HEAD2));
        end else if (pos < body_len) begin
            cur_byte = body_char;
        end else begin
            cur_byte = tail_byte(tpos[1:0]);
        end
    end

    assign o_st.conv_busy = (r_cnt != '0);
    assign o_st.last_byte = (r_idx == last_idx);
    assign o_out_byte     = r_out_byte;
    assign o_out_last     = r_out_last;

    // Conversion counter and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= CNT_W'(CONV_CYCLES);
            r_idx <= '0;
        end else begin
            if (i_cmd.step) r_cnt <= r_cnt - 1'b1;
            if (i_cmd.emit) r_idx <= r_idx + 5'd1;
        end
    end

    // Request fields, converter and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req.op;
            r_id   <= i_req.control_id;
            r_text <= load_text;
            r_sr   <= {{(4*DIGITS){1'b0}}, load_val};
        end else if (i_cmd.step) begin
            r_sr <= dd_step(r_sr);
        end
        if (i_cmd.emit) begin
            r_out_byte <= cur_byte;
            r_out_last <= o_st.last_byte;
        end
    end
endmodule

>>> src/display_text_frame_encoder.sv
// Display text frame encoder: one request in, 11 to 29 frame bytes out.
// The first byte is presented from the output register once the controller has entered its run
// state and that register is free, then one byte per cycle while the sink is ready. A request gives
// 11 bytes (clear only, or a frequency of ten million and up), 25 to 29 (frequency), 26 (d.dd) or
// 25 (d.d), and the next request is taken in the cycle after its last byte is registered;
// the decimal conversion runs under the clear frame.
// Synchronous active-low reset empties the output and returns the controller to idle.
module display_text_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtfe_chan_if.sink   i_req,
    dtfe_chan_if.source o_rsp
);
    import dtfe_pkg::*;

    t_cmd       cmd;
    t_status    st;
    logic [7:0] out_byte;
    logic       out_last;
    logic       in_ready;
    logic       out_valid;

    dtfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_st        (st)
    );

    dtfe_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req.data),
        .i_cmd      (cmd),
        .o_st       (st),
        .o_out_byte (out_byte),
        .o_out_last (out_last)
    );

    assign i_req.ready         = in_ready;
    assign o_rsp.valid         = out_valid;
    assign o_rsp.data.out_byte = out_byte;
    assign o_rsp.data.last     = out_last;

    // Hold off new requests while one is in progress
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && in_ready |=> !in_ready)
        else $error("request accepted while previous request in progress");

    // Start conversion on every load
    a_conv_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> st.conv_busy)
        else $error("decimal conversion did not start");

    // Release the input once the final byte is registered
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit && st.last_byte |=> in_ready && out_valid && out_last)
        else $error("final byte not flagged or controller not idle");
endmodule

>>> bench/dtfe_frame_checker.sv
// Frame byte checker for the display text frame encoder testbench.
// Watches both channels, predicts the byte stream of each request and compares.
// Depends on dtfe_pkg for the item types and op codes.
module dtfe_frame_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  dtfe_pkg::t_req    i_req,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    input  dtfe_pkg::t_rsp    i_rsp,
    output int                o_errors,
    output int                o_pending,
    output int                o_bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import dtfe_pkg::*;

    // Frame bytes, first byte in the top octet
    localparam logic [47:0] FRAME_HEAD   = 48'hEE_B1_10_00_00_00;
    localparam logic [31:0] FRAME_TAIL   = 32'hFF_FC_FF_FF;
    localparam logic [7:0]  CHAR_ZERO    = 8'd48;
    localparam logic [7:0]  CHAR_DOT     = 8'h2E;
    localparam logic [31:0] FREQ_CEILING = 32'd10_000_000;
    localparam logic [31:0] TWO_DEC_MAX  = 32'd999;
    localparam logic [31:0] ONE_DEC_MAX  = 32'd99;

    t_rsp expected_bytes[$];
    int   mismatch_count = 0;
    int   checked_count  = 0;

    function automatic void push_byte(input logic [7:0] b);
        t_rsp r;
        r.out_byte = b;
        r.last     = 1'b0;
        expected_bytes.push_back(r);
    endfunction

    function automatic void push_head(input logic [7:0] id);
        for (int i = 0; i < 6; i++) push_byte(FRAME_HEAD[47 - 8 * i -: 8]);
        push_byte(id);
    endfunction

    function automatic void push_tail();
        for (int i = 0; i < 4; i++) push_byte(FRAME_TAIL[31 - 8 * i -: 8]);
    endfunction

    // Queue the clear frame, then the text frame that the op asks for
    function automatic void predict_frames(input t_req r);
        logic [31:0] v;
        logic [7:0]  digits [7];
        int          n;
        push_head(r.control_id);
        push_tail();
        case (r.op)
            OP_FREQ: begin
                // values of ten million and up get the clear frame alone
                if (r.value < FREQ_CEILING) begin
                    push_head(r.control_id);
                    v = r.value;
                    n = 0;
                    do begin
                        digits[n] = 8'(CHAR_ZERO + v % 10);
                        v = v / 10;
                        n++;
                    end while (v != 0);
                    // pad short values to three digits
                    while (n < 3) begin
                        digits[n] = CHAR_ZERO;
                        n++;
                    end
                    for (int i = n - 1; i >= 0; i--) push_byte(digits[i]);
                    push_tail();
                end
            end
            OP_DEC2: begin
                v = (r.value > TWO_DEC_MAX) ? TWO_DEC_MAX : r.value;
                push_head(r.control_id);
                push_byte(8'(CHAR_ZERO + v / 100));
                push_byte(CHAR_DOT);
                push_byte(8'(CHAR_ZERO + (v % 100) / 10));
                push_byte(8'(CHAR_ZERO + v % 10));
                push_tail();
            end
            OP_DEC1: begin
                v = (r.value > ONE_DEC_MAX) ? ONE_DEC_MAX : r.value;
                push_head(r.control_id);
                push_byte(8'(CHAR_ZERO + v / 10));
                push_byte(CHAR_DOT);
                push_byte(8'(CHAR_ZERO + v % 10));
                push_tail();
            end
            default: begin
            end
        endcase
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    // Predict on each accepted request, compare each accepted byte
    always @(posedge i_clk) begin : watch_channels
        t_rsp want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) predict_frames(i_req);
            if (i_rsp_valid && i_rsp_ready) begin
                checked_count++;
                if (expected_bytes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected byte, expected none, got byte %02h last %b",
                             $time, i_rsp.out_byte, i_rsp.last);
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_rsp.out_byte !== want.out_byte) begin
                        mismatch_count++;
                        $display("%0t: out_byte expected %02h got %02h",
                                 $time, want.out_byte, i_rsp.out_byte);
                    end
                    if (i_rsp.last !== want.last) begin
                        mismatch_count++;
                        $display("%0t: last expected %b got %b (byte %02h)",
                                 $time, want.last, i_rsp.last, i_rsp.out_byte);
                    end
                end
            end
        end
        o_errors        <= mismatch_count;
        o_pending       <= expected_bytes.size();
        o_bytes_checked <= checked_count;
    end

endmodule

>>> bench/tb_display_text_frame_encoder.sv
// Testbench top for the display text frame encoder: clock, reset, request stimulus,
// random output stalls and the verdict. Depends on dtfe_pkg, dtfe_chan_if,
// the encoder itself and dtfe_frame_checker.
module tb_display_text_frame_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import dtfe_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 64;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dtfe_chan_if #(.T(t_req)) req_ch ();
    dtfe_chan_if #(.T(t_rsp)) rsp_ch ();

    int frame_errors;
    int bytes_pending;
    int bytes_checked;
    int cycle_count = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int stall_left  = 0;
    int op_count [4];

    display_text_frame_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    dtfe_frame_checker frame_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_ch.valid),
        .i_req_ready     (req_ch.ready),
        .i_req           (req_ch.data),
        .i_rsp_valid     (rsp_ch.valid),
        .i_rsp_ready     (rsp_ch.ready),
        .i_rsp           (rsp_ch.data),
        .o_errors        (frame_errors),
        .o_pending       (bytes_pending),
        .o_bytes_checked (bytes_checked)
    );

    always #10 i_clk = ~i_clk;

    // Stall the byte sink in bursts at random
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left   <= $urandom_range(0, 6);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d bytes still expected",
                 cycle_count, bytes_pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one request, with an optional idle burst ahead of it, and hold until taken
    task automatic send_request(input logic [1:0] op, input logic [7:0] id,
                                input logic [31:0] value);
        t_req r;
        if ($urandom_range(0, 99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        r.op         = op;
        r.control_id = id;
        r.value      = value;
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        op_count[op]++;
    endtask

    // Spread values over every digit count and the saturation ranges
    function automatic logic [31:0] pick_value(input logic [1:0] op);
        int unsigned decade;
        int unsigned n;
        decade = 1;
        if ($urandom_range(0, 9) < 2) return $urandom;
        case (op)
            OP_FREQ: begin
                n = $urandom_range(1, 8);
                if (n == 8) return $urandom_range(32'hFFFF_FFFF, 10_000_000);
                repeat (n - 1) decade = decade * 10;
                return $urandom_range(decade * 10 - 1, (n == 1) ? 0 : decade);
            end
            OP_DEC2: return $urandom_range(1100, 0);
            OP_DEC1: return $urandom_range(120, 0);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [1:0] op;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        for (int i = 0; i < 4; i++) op_count[i] = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, digit-count edges, saturation and the size limit
        gap_pct   = 20;
        stall_pct = 15;
        send_request(OP_CLEAR, 8'h00, 32'h0000_0000);
        send_request(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_FREQ,  8'h01, 32'd0);
        send_request(OP_FREQ,  8'h80, 32'd7);
        send_request(OP_FREQ,  8'h7F, 32'd999);
        send_request(OP_FREQ,  8'h55, 32'd1000);
        send_request(OP_FREQ,  8'hAA, 32'd9999);
        send_request(OP_FREQ,  8'h12, 32'd10000);
        send_request(OP_FREQ,  8'h34, 32'd99999);
        send_request(OP_FREQ,  8'h56, 32'd100000);
        send_request(OP_FREQ,  8'h78, 32'd999999);
        send_request(OP_FREQ,  8'h9A, 32'd1000000);
        send_request(OP_FREQ,  8'hBC, 32'd1234567);
        send_request(OP_FREQ,  8'hDE, 32'd9999999);
        send_request(OP_FREQ,  8'hF0, 32'd10000000);
        send_request(OP_FREQ,  8'h0F, 32'hFFFF_FFFF);
        send_request(OP_DEC2,  8'h00, 32'd0);
        send_request(OP_DEC2,  8'hFF, 32'd999);
        send_request(OP_DEC2,  8'h21, 32'd1000);
        send_request(OP_DEC2,  8'h43, 32'hFFFF_FFFF);
        send_request(OP_DEC2,  8'h65, 32'd505);
        send_request(OP_DEC1,  8'h00, 32'd0);
        send_request(OP_DEC1,  8'hFF, 32'd99);
        send_request(OP_DEC1,  8'h87, 32'd100);
        send_request(OP_DEC1,  8'hA9, 32'hFFFF_FFFF);

        // Random: idle bursts, then a clean stretch, heavier idling, and a quiet tail
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 0) begin
                gap_pct   = 25;
                stall_pct = 20;
            end else if (i == 140) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (i == 280) begin
                gap_pct   = 40;
                stall_pct = 30;
            end else if (i == 380) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            op = 2'($urandom_range(0, 3));
            send_request(op, 8'($urandom_range(0, 255)), pick_value(op));
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding bytes, then watch for strays
        @(posedge i_clk);
        while (bytes_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d clear, %0d frequency, %0d d.dd, %0d d.d",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[OP_CLEAR], op_count[OP_FREQ], op_count[OP_DEC2], op_count[OP_DEC1]);
        $display("Compared %0d frame bytes under random gaps and sink stalls, %0d errors",
                 bytes_checked, frame_errors);
        if (frame_errors == 0 && bytes_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
